// ===== hdl/sld_pkg.sv =====
`timescale 1ns / 1ps

package sld_pkg;

  localparam logic [2:0] ST_EXISTING = 3'd0;
  localparam logic [2:0] ST_NEW      = 3'd1;
  localparam logic [2:0] ST_FULL     = 3'd2;
  localparam logic [2:0] ST_RELEASED = 3'd3;
  localparam logic [2:0] ST_ABSENT   = 3'd4;

  localparam logic MODE_ASSIGN  = 1'b0;
  localparam logic MODE_RELEASE = 1'b1;

  localparam logic CFG_WORKERS_IN_USE = 1'b0;
  localparam logic CFG_MAX_PER_WORKER = 1'b1;

  typedef struct packed {
    logic        mode;
    logic [63:0] session_key;
    logic [2:0]  release_worker;
  } sld_in_t;

  typedef struct packed {
    logic [2:0] status;
    logic [2:0] chosen_worker;
    logic [8:0] entry_slot;
  } sld_out_t;

endpackage

// ===== hdl/sld_ram.sv =====
`timescale 1ns / 1ps

module sld_ram #(
  parameter int WIDTH = 65,
  parameter int DEPTH = 512
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hdl/sticky_least_loaded_dispatch_core.sv =====
`timescale 1ns / 1ps
// An assign request scans the slots of every active worker, a release request only the slots of
// the named worker; a hit ends the key scan early, and a request with no worker to scan answers
// in the cycle after start. One request at a time; the single key-store read port sets the rate
// at one slot per cycle. Synchronous active-low reset, then a clearing pass over all
// NUM_WORKERS*SLOTS_PER_WORKER entries with busy high. Results appear on a one-cycle strobe.
module sticky_least_loaded_dispatch_core #(
  parameter int NUM_WORKERS      = 8,
  parameter int SLOTS_PER_WORKER = 64,
  parameter int KEY_BITS         = 64
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  sld_pkg::sld_in_t  in_data,
  output logic              out_valid,
  output sld_pkg::sld_out_t out_data,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic              cfg_index,
  input  logic [6:0]        cfg_wdata
);

  import sld_pkg::*;

  localparam int TOTAL = NUM_WORKERS * SLOTS_PER_WORKER;
  localparam int AW    = (TOTAL > 1) ? $clog2(TOTAL) : 1;
  localparam int WW    = (NUM_WORKERS > 1) ? $clog2(NUM_WORKERS) : 1;
  localparam int SW    = (SLOTS_PER_WORKER > 1) ? $clog2(SLOTS_PER_WORKER) : 1;
  localparam int LW    = $clog2(SLOTS_PER_WORKER + 1);
  localparam int NW    = $clog2(NUM_WORKERS + 1);
  localparam int CW    = (NW > 4) ? NW : 4;
  localparam int LCW   = (LW > 7) ? LW : 7;
  localparam int RW    = KEY_BITS + 1;

  localparam logic [AW-1:0] LAST_ADDR = AW'(TOTAL - 1);
  localparam logic [SW-1:0] LAST_SLOT = SW'(SLOTS_PER_WORKER - 1);

  localparam logic [1:0] S_CLEAR = 2'd0;
  localparam logic [1:0] S_IDLE  = 2'd1;
  localparam logic [1:0] S_SCAN  = 2'd2;

  logic [1:0]          state_r, state_nxt;
  logic [AW-1:0]       addr_r, addr_nxt;
  logic [WW-1:0]       w_r, w_nxt;
  logic [SW-1:0]       s_r, s_nxt;
  logic                iss_on_r, iss_on_nxt;
  logic [WW-1:0]       w_end_r, w_end_nxt;
  logic                mode_r, mode_nxt;
  logic [KEY_BITS-1:0] key_r, key_nxt;
  logic [WW-1:0]       rel_r, rel_nxt;

  logic                p_valid_r, p_valid_nxt;
  logic [AW-1:0]       p_addr_r, p_addr_nxt;
  logic [WW-1:0]       p_w_r, p_w_nxt;
  logic                p_last_r, p_last_nxt;
  logic                p_isbest_r, p_isbest_nxt;

  logic [WW-1:0]       best_r, best_nxt;
  logic [LW-1:0]       best_load_r, best_load_nxt;
  logic                best_has_free_r, best_has_free_nxt;
  logic [AW-1:0]       best_free_r, best_free_nxt;

  logic [3:0]          workers_r;
  logic [6:0]          max_r;
  logic [LW-1:0]       load_r [NUM_WORKERS];

  logic                out_valid_r, out_valid_nxt;
  sld_out_t            out_r, out_nxt;

  logic                ram_we;
  logic [AW-1:0]       ram_waddr;
  logic [RW-1:0]       ram_wdata;
  logic [RW-1:0]       ram_rdata;

  logic                ld_we;
  logic [WW-1:0]       ld_widx;
  logic [LW-1:0]       ld_wval;
  logic [WW-1:0]       ld_ridx;
  logic [LW-1:0]       ld_rd;

  logic [CW-1:0]       n_act;
  logic [LCW-1:0]      lim;
  logic                rel_ok;
  logic [AW-1:0]       rel_base;
  logic                is_last;
  logic                take;
  logic                hit;
  logic                free;

  sld_ram #(
    .WIDTH (RW),
    .DEPTH (TOTAL)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (addr_r),
    .rdata (ram_rdata)
  );

  assign busy      = (state_r != S_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  assign n_act    = (CW'(workers_r) > CW'(NUM_WORKERS)) ? CW'(NUM_WORKERS) : CW'(workers_r);
  assign lim      = (LCW'(max_r) > LCW'(SLOTS_PER_WORKER)) ? LCW'(SLOTS_PER_WORKER)
                                                           : LCW'(max_r);
  assign rel_ok   = CW'(in_data.release_worker) < n_act;
  assign rel_base = AW'(int'(in_data.release_worker) * SLOTS_PER_WORKER);
  assign is_last  = (s_r == LAST_SLOT) && (w_r == w_end_r);
  assign ld_ridx  = mode_r ? rel_r : w_r;
  assign ld_rd    = load_r[ld_ridx];
  assign take     = (w_r == '0) || (ld_rd < best_load_r);
  assign hit      = p_valid_r && ram_rdata[KEY_BITS] && (ram_rdata[KEY_BITS-1:0] == key_r);
  assign free     = p_valid_r && !ram_rdata[KEY_BITS];

  always_comb begin
    state_nxt         = state_r;
    addr_nxt          = addr_r;
    w_nxt             = w_r;
    s_nxt             = s_r;
    iss_on_nxt        = iss_on_r;
    w_end_nxt         = w_end_r;
    mode_nxt          = mode_r;
    key_nxt           = key_r;
    rel_nxt           = rel_r;
    p_valid_nxt       = 1'b0;
    p_addr_nxt        = addr_r;
    p_w_nxt           = w_r;
    p_last_nxt        = is_last;
    p_isbest_nxt      = 1'b0;
    best_nxt          = best_r;
    best_load_nxt     = best_load_r;
    best_has_free_nxt = best_has_free_r;
    best_free_nxt     = best_free_r;
    out_valid_nxt     = 1'b0;
    out_nxt           = out_r;
    ram_we            = 1'b0;
    ram_waddr         = p_addr_r;
    ram_wdata         = {1'b1, key_r};
    ld_we             = 1'b0;
    ld_widx           = rel_r;
    ld_wval           = ld_rd;

    unique case (state_r)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = addr_r;
        ram_wdata = '0;
        addr_nxt  = addr_r + 1'b1;
        if (addr_r == LAST_ADDR) begin
          addr_nxt  = '0;
          state_nxt = S_IDLE;
        end
      end

      S_IDLE: begin
        if (start) begin
          mode_nxt = in_data.mode;
          key_nxt  = in_data.session_key[KEY_BITS-1:0];
          rel_nxt  = WW'(in_data.release_worker);
          s_nxt    = '0;
          if (in_data.mode == MODE_ASSIGN) begin
            if (n_act == '0) begin
              out_valid_nxt = 1'b1;
              out_nxt       = '{status: ST_FULL, chosen_worker: 3'd0, entry_slot: 9'd0};
            end else begin
              state_nxt  = S_SCAN;
              addr_nxt   = '0;
              w_nxt      = '0;
              w_end_nxt  = WW'(n_act - 1'b1);
              iss_on_nxt = 1'b1;
            end
          end else begin
            if (!rel_ok) begin
              out_valid_nxt = 1'b1;
              out_nxt       = '{status: ST_ABSENT, chosen_worker: in_data.release_worker,
                                entry_slot: 9'd0};
            end else begin
              state_nxt  = S_SCAN;
              addr_nxt   = rel_base;
              w_nxt      = WW'(in_data.release_worker);
              w_end_nxt  = WW'(in_data.release_worker);
              iss_on_nxt = 1'b1;
            end
          end
        end
      end

      S_SCAN: begin
        if ((mode_r == MODE_ASSIGN) && free && p_isbest_r && !best_has_free_r) begin
          best_has_free_nxt = 1'b1;
          best_free_nxt     = p_addr_r;
        end

        if (iss_on_r) begin
          p_valid_nxt = 1'b1;
          addr_nxt    = addr_r + 1'b1;
          if (s_r == LAST_SLOT) begin
            s_nxt = '0;
            w_nxt = w_r + 1'b1;
          end else begin
            s_nxt = s_r + 1'b1;
          end
          if (is_last) begin
            iss_on_nxt = 1'b0;
          end
          if (mode_r == MODE_ASSIGN) begin
            p_isbest_nxt = (best_r == w_r);
            if ((s_r == '0) && take) begin
              best_nxt          = w_r;
              best_load_nxt     = ld_rd;
              best_has_free_nxt = 1'b0;
              p_isbest_nxt      = 1'b1;
            end
          end
        end

        if (hit || (p_valid_r && p_last_r)) begin
          state_nxt   = S_IDLE;
          iss_on_nxt  = 1'b0;
          p_valid_nxt = 1'b0;
          out_valid_nxt = 1'b1;
          if (mode_r == MODE_ASSIGN) begin
            if (hit) begin
              out_nxt = '{status: ST_EXISTING, chosen_worker: 3'(p_w_r),
                          entry_slot: 9'(p_addr_r)};
            end else if ((LCW'(best_load_r) < lim) && best_has_free_nxt) begin
              ram_we    = 1'b1;
              ram_waddr = best_free_nxt;
              ram_wdata = {1'b1, key_r};
              ld_we     = 1'b1;
              ld_widx   = best_r;
              ld_wval   = best_load_r + 1'b1;
              out_nxt   = '{status: ST_NEW, chosen_worker: 3'(best_r),
                            entry_slot: 9'(best_free_nxt)};
            end else begin
              out_nxt = '{status: ST_FULL, chosen_worker: 3'd0, entry_slot: 9'd0};
            end
          end else begin
            if (hit) begin
              ram_we    = 1'b1;
              ram_waddr = p_addr_r;
              ram_wdata = {1'b0, key_r};
              ld_we     = 1'b1;
              ld_widx   = rel_r;
              ld_wval   = (ld_rd != '0) ? ld_rd - 1'b1 : ld_rd;
              out_nxt   = '{status: ST_RELEASED, chosen_worker: 3'(rel_r),
                            entry_slot: 9'(p_addr_r)};
            end else begin
              out_nxt = '{status: ST_ABSENT, chosen_worker: 3'(rel_r), entry_slot: 9'd0};
            end
          end
        end
      end

      default: begin
        state_nxt = S_CLEAR;
        addr_nxt  = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      addr_r      <= '0;
      iss_on_r    <= 1'b0;
      p_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
      workers_r   <= 4'd8;
      max_r       <= 7'd64;
      for (int i = 0; i < NUM_WORKERS; i++) begin
        load_r[i] <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      addr_r      <= addr_nxt;
      iss_on_r    <= iss_on_nxt;
      p_valid_r   <= p_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          CFG_WORKERS_IN_USE: workers_r <= cfg_wdata[3:0];
          CFG_MAX_PER_WORKER: max_r     <= cfg_wdata;
          default: ;
        endcase
      end
      if (ld_we) begin
        load_r[ld_widx] <= ld_wval;
      end
    end
  end

  always_ff @(posedge clk) begin
    w_r             <= w_nxt;
    s_r             <= s_nxt;
    w_end_r         <= w_end_nxt;
    mode_r          <= mode_nxt;
    key_r           <= key_nxt;
    rel_r           <= rel_nxt;
    p_addr_r        <= p_addr_nxt;
    p_w_r           <= p_w_nxt;
    p_last_r        <= p_last_nxt;
    p_isbest_r      <= p_isbest_nxt;
    best_r          <= best_nxt;
    best_load_r     <= best_load_nxt;
    best_has_free_r <= best_has_free_nxt;
    best_free_r     <= best_free_nxt;
    out_r           <= out_nxt;
  end

endmodule

// ===== hdl/sld_checker.sv =====
`timescale 1ns / 1ps

module sld_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              start,
  input logic              busy,
  input sld_pkg::sld_in_t  in_data,
  input logic              out_valid,
  input sld_pkg::sld_out_t out_data,
  input logic              cfg_valid,
  input logic              cfg_ready,
  input logic              cfg_index,
  input logic [6:0]        cfg_wdata
);

  import sld_pkg::*;

  a_accept_then_work: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> (busy || out_valid))
    else $error("accepted beat neither busy nor answered");

  a_result_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result beat while still busy");

  a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.status == ST_EXISTING || out_data.status == ST_NEW ||
                   out_data.status == ST_FULL || out_data.status == ST_RELEASED ||
                   out_data.status == ST_ABSENT))
    else $error("unknown status code");

  a_full_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.status == ST_FULL) |->
      (out_data.chosen_worker == 3'd0 && out_data.entry_slot == 9'd0))
    else $error("rejected beat carries worker or slot");

  a_absent_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.status == ST_ABSENT) |-> (out_data.entry_slot == 9'd0))
    else $error("absent beat carries slot");

endmodule

bind sticky_least_loaded_dispatch_core sld_checker u_sld_checker (.*);
